// ----- src/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int PAGES_DEF      = 16;
   localparam int LEVELS_DEF     = 8;
   localparam int LEAF_BYTES_DEF = 32;

   localparam int BYTES_W = 16;
   localparam int ADDR_W  = 16;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC_FIT,
      ST_ALLOC_FIND,
      ST_ALLOC_POP,
      ST_ALLOC_MARK,
      ST_ALLOC_SPLIT,
      ST_FREE_START,
      ST_FREE_SEARCH,
      ST_FREE_MERGE,
      ST_FREE_BUDDY,
      ST_FREE_UP,
      ST_UNLINK_RD,
      ST_UNLINK_CHK,
      ST_PUSH_RD,
      ST_PUSH_CHK,
      ST_PUSH_LINK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               mode;
      logic [BYTES_W-1:0] request_bytes;
      logic [ADDR_W-1:0]  block_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] granted_address;
      logic              ok;
   } rsp_type;

endpackage

// ----- src/bba_ram.sv -----
// ----------------------------------------------------------------------------
// bba_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/bba_core.sv -----
// ----------------------------------------------------------------------------
// bba_core
// Allocation sequencer: per-level mark RAMs, node link and status RAMs,
// free list heads, and the state machine that walks them.
// ----------------------------------------------------------------------------
module bba_core #(
   parameter int PAGES      = bba_pkg::PAGES_DEF,
   parameter int LEVELS     = bba_pkg::LEVELS_DEF,
   parameter int LEAF_BYTES = bba_pkg::LEAF_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  bba_pkg::req_type in_req,
   output logic             busy,
   input  logic             out_free,
   output logic             out_done,
   output bba_pkg::rsp_type out_rsp
);
   import bba_pkg::*;

   localparam int LEAF_SH     = $clog2(LEAF_BYTES);
   localparam int PAGE_LEAVES = 1 << (LEVELS - 1);
   localparam int TOTAL       = PAGES * PAGE_LEAVES;
   localparam int NODE_W      = $clog2(TOTAL);
   localparam int LVL_W       = $clog2(LEVELS);
   localparam int CNT_W       = $clog2(TOTAL + 1);
   localparam int ST_W        = 1 + LVL_W;

   localparam logic [LVL_W-1:0]  TOP_LVL   = LVL_W'(LEVELS - 1);
   localparam logic [NODE_W-1:0] PAGE_STEP = NODE_W'(PAGE_LEAVES);
   localparam logic [NODE_W-1:0] PAGE_MASK = NODE_W'(PAGE_LEAVES - 1);
   localparam logic [NODE_W-1:0] LAST_PAGE = NODE_W'((PAGES - 1) * PAGE_LEAVES);
   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(TOTAL - 1);

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [LVL_W-1:0]   k_ff, k_in, fk_ff, fk_in;
   logic [NODE_W-1:0]  p_ff, p_in, e_ff, e_in, cnt_ff, cnt_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic [ADDR_W-1:0]  baddr_ff, baddr_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic               res_ok_ff, res_ok_in;
   logic [NODE_W-1:0]  first_ff [LEVELS];
   logic [NODE_W-1:0]  first_in [LEVELS];
   logic [NODE_W-1:0]  last_ff  [LEVELS];
   logic [NODE_W-1:0]  last_in  [LEVELS];
   logic [CNT_W-1:0]   count_ff [LEVELS];
   logic [CNT_W-1:0]   count_in [LEVELS];

   logic [LEVELS-1:0]  mark_rd, mark_we;
   logic               mark_wd;
   logic [NODE_W-1:0]  mark_wnode, mark_rnode;
   logic [ST_W-1:0]    st_rd, st_wd;
   logic               st_we;
   logic [NODE_W-1:0]  st_wa;
   logic [NODE_W-1:0]  next_rd, next_wa, next_wd, prev_rd, prev_wa, prev_wd;
   logic               next_we, prev_we;

   logic               st_listed;
   logic [LVL_W-1:0]   st_lvl, lvl_sel, fit_k, find_k, search_k;
   logic               fit_any, find_any, search_any, do_unlink, beyond;
   logic [NODE_W-1:0]  first_sel, last_sel, onehot_k, onehot_km1, leaf_node;
   logic [CNT_W-1:0]   count_sel;
   logic [31:0]        leaf32;

   // mark RAMs, one per level, indexed by block number at that level
   for (genvar g = 0; g < LEVELS; g++) begin : g_mark
      localparam int DK = TOTAL >> g;
      localparam int AK = (DK > 1) ? $clog2(DK) : 1;
      logic [0:0] rd_bit;
      bba_ram #(.WIDTH(1), .DEPTH(DK), .ADDR_W(AK)) u_mark (
         .clock   (clock),
         .wr_en   (mark_we[g]),
         .wr_addr (AK'(mark_wnode >> g)),
         .wr_data (mark_wd),
         .rd_addr (AK'(mark_rnode >> g)),
         .rd_data (rd_bit)
      );
      assign mark_rd[g] = rd_bit[0];
   end

   bba_ram #(.WIDTH(ST_W), .DEPTH(TOTAL), .ADDR_W(NODE_W)) u_status (
      .clock (clock), .wr_en (st_we), .wr_addr (st_wa), .wr_data (st_wd),
      .rd_addr (e_ff), .rd_data (st_rd)
   );

   bba_ram #(.WIDTH(NODE_W), .DEPTH(TOTAL), .ADDR_W(NODE_W)) u_next (
      .clock (clock), .wr_en (next_we), .wr_addr (next_wa), .wr_data (next_wd),
      .rd_addr (e_ff), .rd_data (next_rd)
   );

   bba_ram #(.WIDTH(NODE_W), .DEPTH(TOTAL), .ADDR_W(NODE_W)) u_prev (
      .clock (clock), .wr_en (prev_we), .wr_addr (prev_wa), .wr_data (prev_wd),
      .rd_addr (e_ff), .rd_data (prev_rd)
   );

   assign st_listed  = st_rd[ST_W-1];
   assign st_lvl     = st_rd[LVL_W-1:0];
   assign lvl_sel    = (state_ff == ST_PUSH_CHK) ? st_lvl : k_ff;
   assign first_sel  = first_ff[lvl_sel];
   assign last_sel   = last_ff[lvl_sel];
   assign count_sel  = count_ff[lvl_sel];
   assign onehot_k   = NODE_W'(1) << k_ff;
   assign onehot_km1 = NODE_W'(1) << (k_ff - LVL_W'(1));
   assign leaf32     = 32'(baddr_ff) >> LEAF_SH;
   assign beyond     = leaf32 >= 32'(TOTAL);
   assign leaf_node  = NODE_W'(leaf32);
   assign busy       = (state_ff != ST_IDLE);
   assign out_rsp    = '{granted_address: res_addr_ff, ok: res_ok_ff};

   // smallest fitting level, first non-empty level, lowest marked level
   always_comb begin
      fit_any    = 1'b0;
      fit_k      = '0;
      find_any   = 1'b0;
      find_k     = '0;
      search_any = 1'b0;
      search_k   = '0;
      for (int j = LEVELS - 1; j >= 0; j--) begin
         if (32'(bytes_ff) <= (32'(LEAF_BYTES) << j)) begin
            fit_any = 1'b1;
            fit_k   = LVL_W'(j);
         end
         if (count_ff[j] != '0 && LVL_W'(j) >= fk_ff) begin
            find_any = 1'b1;
            find_k   = LVL_W'(j);
         end
         if (mark_rd[j]) begin
            search_any = 1'b1;
            search_k   = LVL_W'(j);
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      k_in        = k_ff;
      fk_in       = fk_ff;
      p_in        = p_ff;
      e_in        = e_ff;
      cnt_in      = cnt_ff;
      bytes_in    = bytes_ff;
      baddr_in    = baddr_ff;
      res_addr_in = res_addr_ff;
      res_ok_in   = res_ok_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      count_in    = count_ff;
      mark_we     = '0;
      mark_wd     = 1'b0;
      mark_wnode  = p_ff;
      mark_rnode  = p_ff;
      st_we       = 1'b0;
      st_wa       = e_ff;
      st_wd       = '0;
      next_we     = 1'b0;
      next_wa     = e_ff;
      next_wd     = '0;
      prev_we     = 1'b0;
      prev_wa     = e_ff;
      prev_wd     = '0;
      out_done    = 1'b0;
      do_unlink   = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mark_we    = '1;
            mark_wnode = cnt_ff;
            st_we      = 1'b1;
            st_wa      = cnt_ff;
            st_wd      = {((cnt_ff & PAGE_MASK) == '0), TOP_LVL};
            next_we    = 1'b1;
            next_wa    = cnt_ff;
            next_wd    = cnt_ff - PAGE_STEP;
            prev_we    = 1'b1;
            prev_wa    = cnt_ff;
            prev_wd    = cnt_ff + PAGE_STEP;
            cnt_in     = cnt_ff + NODE_W'(1);
            if (cnt_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (in_valid) begin
               bytes_in = in_req.request_bytes;
               baddr_in = in_req.block_address;
               state_in = (in_req.mode == MODE_FREE) ? ST_FREE_START : ST_ALLOC_FIT;
            end
         end
         ST_ALLOC_FIT: begin
            res_addr_in = '0;
            res_ok_in   = 1'b0;
            fk_in       = fit_k;
            state_in    = fit_any ? ST_ALLOC_FIND : ST_DONE;
         end
         ST_ALLOC_FIND: begin
            k_in     = find_k;
            state_in = find_any ? ST_ALLOC_POP : ST_DONE;
         end
         ST_ALLOC_POP: begin
            p_in     = first_sel;
            e_in     = first_sel;
            ret_in   = ST_ALLOC_MARK;
            state_in = ST_UNLINK_RD;
         end
         ST_ALLOC_MARK: begin
            mark_we[k_ff] = 1'b1;
            mark_wd       = 1'b1;
            if (k_ff == fk_ff) begin
               res_addr_in = ADDR_W'(32'(p_ff) << LEAF_SH);
               res_ok_in   = 1'b1;
               state_in    = ST_DONE;
            end else begin
               state_in = ST_ALLOC_SPLIT;
            end
         end
         ST_ALLOC_SPLIT: begin
            mark_we[k_ff - LVL_W'(1)] = 1'b1;
            mark_wd  = 1'b1;
            k_in     = k_ff - LVL_W'(1);
            e_in     = p_ff | onehot_km1;
            ret_in   = ST_ALLOC_MARK;
            state_in = ST_PUSH_RD;
         end
         ST_FREE_START: begin
            res_addr_in = '0;
            res_ok_in   = 1'b1;
            mark_rnode  = leaf_node;
            p_in        = leaf_node;
            state_in    = beyond ? ST_DONE : ST_FREE_SEARCH;
         end
         ST_FREE_SEARCH: begin
            k_in     = search_k;
            p_in     = p_ff & ~((NODE_W'(1) << search_k) - NODE_W'(1));
            state_in = search_any ? ST_FREE_MERGE : ST_DONE;
         end
         ST_FREE_MERGE: begin
            if (k_ff == TOP_LVL) begin
               e_in     = p_ff;
               ret_in   = ST_DONE;
               state_in = ST_PUSH_RD;
            end else begin
               mark_we[k_ff] = 1'b1;
               mark_rnode    = p_ff ^ onehot_k;
               state_in      = ST_FREE_BUDDY;
            end
         end
         ST_FREE_BUDDY: begin
            if (mark_rd[k_ff]) begin
               e_in     = p_ff;
               ret_in   = ST_DONE;
               state_in = ST_PUSH_RD;
            end else begin
               e_in     = p_ff ^ onehot_k;
               ret_in   = ST_FREE_UP;
               state_in = ST_UNLINK_RD;
            end
         end
         ST_FREE_UP: begin
            p_in       = p_ff & ~onehot_k;
            mark_wnode = p_ff & ~onehot_k;
            mark_we[k_ff + LVL_W'(1)] = 1'b1;
            k_in       = k_ff + LVL_W'(1);
            state_in   = ST_FREE_MERGE;
         end
         ST_UNLINK_RD: begin
            state_in = ST_UNLINK_CHK;
         end
         ST_UNLINK_CHK: begin
            do_unlink = st_listed && (st_lvl == k_ff);
            state_in  = ret_ff;
         end
         ST_PUSH_RD: begin
            state_in = ST_PUSH_CHK;
         end
         ST_PUSH_CHK: begin
            do_unlink = st_listed;
            state_in  = ST_PUSH_LINK;
         end
         ST_PUSH_LINK: begin
            if (count_sel == '0) begin
               last_in[lvl_sel] = e_ff;
            end else begin
               prev_we = 1'b1;
               prev_wa = first_sel;
               prev_wd = e_ff;
               next_we = 1'b1;
               next_wa = e_ff;
               next_wd = first_sel;
            end
            first_in[lvl_sel] = e_ff;
            count_in[lvl_sel] = count_sel + CNT_W'(1);
            st_we    = 1'b1;
            st_wa    = e_ff;
            st_wd    = {1'b1, k_ff};
            state_in = ret_ff;
         end
         ST_DONE: begin
            if (out_free) begin
               out_done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_unlink) begin
         if (first_sel == e_ff) begin
            first_in[lvl_sel] = next_rd;
         end else begin
            next_we = 1'b1;
            next_wa = prev_rd;
            next_wd = next_rd;
         end
         if (last_sel == e_ff) begin
            last_in[lvl_sel] = prev_rd;
         end else begin
            prev_we = 1'b1;
            prev_wa = next_rd;
            prev_wd = prev_rd;
         end
         count_in[lvl_sel] = count_sel - CNT_W'(1);
         st_we = 1'b1;
         st_wa = e_ff;
         st_wd = {1'b0, lvl_sel};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ret_ff   <= ST_IDLE;
         cnt_ff   <= '0;
         for (int j = 0; j < LEVELS; j++) begin
            first_ff[j] <= (j == LEVELS - 1) ? LAST_PAGE : '0;
            last_ff[j]  <= '0;
            count_ff[j] <= (j == LEVELS - 1) ? CNT_W'(PAGES) : '0;
         end
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         cnt_ff   <= cnt_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      fk_ff       <= fk_in;
      p_ff        <= p_in;
      e_ff        <= e_in;
      bytes_ff    <= bytes_in;
      baddr_ff    <= baddr_in;
      res_addr_ff <= res_addr_in;
      res_ok_ff   <= res_ok_in;
   end

   a_idle_no_mark: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (mark_we == '0))
      else $error("mark write while idle");

   a_unlink_seq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UNLINK_RD) |=> (state_ff == ST_UNLINK_CHK))
      else $error("unlink read not followed by check");

   a_split_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC_SPLIT) |-> (k_ff > fk_ff))
      else $error("split below requested level");

   a_done_free: assert property (@(posedge clock) disable iff (reset)
      out_done |-> (out_free && state_ff == ST_DONE))
      else $error("result issued without room");

endmodule

// ----- src/buddy_block_allocator.sv -----
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over pages of leaf-sized blocks with per-level free lists.
// ----------------------------------------------------------------------------
// One transaction at a time: the next is accepted once the result is registered and the
// sequencer is idle again; its RAM walks set the pace and a stalled result holds it.
// Reset: synchronous; afterwards a clearing pass over all PAGES << (LEVELS-1)
// nodes (2048 by default) runs with req_stall high.
module buddy_block_allocator #(
   parameter int PAGES      = bba_pkg::PAGES_DEF,
   parameter int LEVELS     = bba_pkg::LEVELS_DEF,
   parameter int LEAF_BYTES = bba_pkg::LEAF_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_mode,
   input  logic [bba_pkg::BYTES_W-1:0]  req_request_bytes,
   input  logic [bba_pkg::ADDR_W-1:0]   req_block_address,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bba_pkg::ADDR_W-1:0]   rsp_granted_address,
   output logic                         rsp_ok
);
   import bba_pkg::*;

   logic    busy, out_free, out_done;
   req_type req;
   rsp_type core_rsp;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   assign req = '{mode: req_mode, request_bytes: req_request_bytes,
                  block_address: req_block_address};

   bba_core #(.PAGES(PAGES), .LEVELS(LEVELS), .LEAF_BYTES(LEAF_BYTES)) u_core (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_req   (req),
      .busy     (busy),
      .out_free (out_free),
      .out_done (out_done),
      .out_rsp  (core_rsp)
   );

   assign req_stall = busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = core_rsp;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_ff.granted_address;
   assign rsp_ok              = rsp_ff.ok;

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for buddy_block_allocator. A predictor keeps its own copy of the
// mark bits and the per-level free lists and works out the granted address
// and status of each accepted transaction. Directed tests cover the size
// extremes, exhaustion of the heap, unaligned frees and frees of addresses
// that were never allocated. A random phase then runs mostly well-formed
// allocate/free traffic with some noise. The sender works in bursts and the
// receiver stalls in shifting patterns.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bba_pkg::*;

   localparam int NUM_LEVELS = LEVELS_DEF;
   localparam int LEAF_SZ    = LEAF_BYTES_DEF;
   localparam int TOP_LVL    = NUM_LEVELS - 1;
   localparam int PAGE_LEAF  = 1 << TOP_LVL;
   localparam int LEAVES     = PAGES_DEF * PAGE_LEAF;
   localparam int PAGE_SZ    = LEAF_SZ * PAGE_LEAF;

   typedef struct {
      logic [ADDR_W-1:0] granted_address;
      logic              ok;
   } grant_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_mode = MODE_ALLOC;
   logic [BYTES_W-1:0]  req_request_bytes = '0;
   logic [ADDR_W-1:0]   req_block_address = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ADDR_W-1:0]   rsp_granted_address;
   logic                rsp_ok;

   buddy_block_allocator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_request_bytes(req_request_bytes), .req_block_address(req_block_address),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_granted_address(rsp_granted_address), .rsp_ok(rsp_ok)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // allocator image
   bit heap_mark [NUM_LEVELS][LEAVES];
   int link_next [LEAVES];
   int link_prev [LEAVES];
   bit in_list   [LEAVES];
   int list_of   [LEAVES];
   int head      [NUM_LEVELS];
   int tail      [NUM_LEVELS];
   int count     [NUM_LEVELS];

   grant_type  pending_grants[$];
   int         live_blocks[$];
   int         errors = 0;
   int         n_alloc = 0, n_free = 0, n_fail = 0, n_checked = 0;
   int         burst_left = 0;

   function automatic void unlink_node(int k, int e);
      int nx, pv;
      if (!in_list[e] || list_of[e] != k) return;
      nx = link_next[e];
      pv = link_prev[e];
      if (head[k] == e) head[k] = nx; else link_next[pv] = nx;
      if (tail[k] == e) tail[k] = pv; else link_prev[nx] = pv;
      count[k]--;
      in_list[e] = 0;
   endfunction

   function automatic void push_node(int k, int e);
      if (in_list[e]) unlink_node(list_of[e], e);
      if (count[k] == 0) begin
         tail[k] = e;
      end else begin
         link_prev[head[k]] = e;
         link_next[e] = head[k];
      end
      head[k] = e;
      count[k]++;
      in_list[e] = 1;
      list_of[e] = k;
   endfunction

   function automatic void clear_heap();
      foreach (heap_mark[k, i]) heap_mark[k][i] = 0;
      foreach (in_list[i]) begin
         in_list[i] = 0; list_of[i] = 0; link_next[i] = 0; link_prev[i] = 0;
      end
      foreach (count[k]) begin
         count[k] = 0; head[k] = 0; tail[k] = 0;
      end
      for (int i = 0; i < PAGES_DEF; i++) push_node(TOP_LVL, i * PAGE_LEAF);
   endfunction

   function automatic grant_type predict_alloc(int nbytes);
      grant_type g;
      int fk, k, p;
      g.granted_address = '0;
      g.ok = 1'b0;
      fk = 0;
      while (fk < NUM_LEVELS && (LEAF_SZ << fk) < nbytes) fk++;
      for (k = fk; k < NUM_LEVELS; k++)
         if (count[k] != 0) break;
      if (k >= NUM_LEVELS) return g;
      p = head[k];
      unlink_node(k, p);
      heap_mark[k][p >> k] = 1;
      for (; k > fk; k--) begin
         heap_mark[k-1][p >> (k-1)] = 1;
         push_node(k - 1, p + (1 << (k - 1)));
      end
      g.granted_address = ADDR_W'(p * LEAF_SZ);
      g.ok = 1'b1;
      return g;
   endfunction

   function automatic void predict_free(int addr);
      int n, k, p, bi, buddy, q;
      n = addr / LEAF_SZ;
      if (n >= LEAVES) return;
      for (k = 0; k < NUM_LEVELS; k++)
         if (heap_mark[k][n >> k]) break;
      if (k >= NUM_LEVELS) return;
      p = (n >> k) << k;
      for (; k < TOP_LVL; k++) begin
         bi = p >> k;
         buddy = bi ^ 1;
         q = buddy << k;
         heap_mark[k][bi] = 0;
         if (heap_mark[k][buddy]) break;
         unlink_node(k, q);
         if ((buddy & 1) == 0) p = q;
         heap_mark[k+1][p >> (k+1)] = 0;
      end
      push_node(k, p);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] MISMATCH %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
      errors++;
   endtask

   // one transaction on the request channel; caller sits at a rising edge
   task automatic send_request(logic mode, int nbytes, int addr);
      grant_type g;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_request_bytes <= BYTES_W'(nbytes);
      req_block_address <= ADDR_W'(addr);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (mode == MODE_ALLOC) begin
         g = predict_alloc(nbytes);
         n_alloc++;
         if (g.ok) live_blocks.push_back(int'(g.granted_address));
         else n_fail++;
      end else begin
         predict_free(addr);
         g.granted_address = '0;
         g.ok = 1'b1;
         n_free++;
      end
      pending_grants.push_back(g);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic free_live(int idx);
      int a;
      a = live_blocks[idx];
      live_blocks.delete(idx);
      send_request(MODE_FREE, 0, a);
   endtask

   task automatic test_size_extremes();
      send_request(MODE_ALLOC, 0, 0);
      send_request(MODE_ALLOC, 1, 16'hFFFF);
      send_request(MODE_ALLOC, 32, 0);
      send_request(MODE_ALLOC, 33, 0);
      send_request(MODE_ALLOC, 2048, 0);
      send_request(MODE_ALLOC, 4096, 0);
      send_request(MODE_ALLOC, 4097, 0);
      send_request(MODE_ALLOC, 65535, 0);
      // unaligned free of a live block, then a double free
      send_request(MODE_FREE, 16'hFFFF, live_blocks[1] + 17);
      send_request(MODE_FREE, 16'hFFFF, live_blocks[1]);
      live_blocks.delete(1);
      // never-allocated address and the top of the address space
      send_request(MODE_FREE, 0, 16'hFFFF);
      send_request(MODE_FREE, 0, 16'h8000);
      while (live_blocks.size() != 0) free_live(0);
   endtask

   task automatic test_exhaustion();
      for (int i = 0; i < PAGES_DEF; i++) send_request(MODE_ALLOC, PAGE_SZ, 0);
      send_request(MODE_ALLOC, 0, 0);
      free_live(3);
      send_request(MODE_ALLOC, 100, 0);
      send_request(MODE_ALLOC, 4096, 0);
      while (live_blocks.size() != 0) free_live($urandom_range(0, live_blocks.size() - 1));
   endtask

   function automatic int pick_size();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(4097, 65535);
         1, 2:    return $urandom_range(1024, 4096);
         3:       return $urandom_range(0, 1);
         default: return $urandom_range(2, 600);
      endcase
   endfunction

   task automatic test_random_traffic(int items);
      int sel;
      for (int i = 0; i < items; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 6) begin
            send_request(MODE_FREE, $urandom_range(0, 65535), $urandom_range(0, 65535));
         end else if (sel < 9 && live_blocks.size() != 0) begin
            send_request(MODE_FREE, 0,
               live_blocks[$urandom_range(0, live_blocks.size() - 1)] + $urandom_range(0, 31));
         end else if (live_blocks.size() != 0 && (sel < 50 || live_blocks.size() > 40)) begin
            free_live($urandom_range(0, live_blocks.size() - 1));
         end else begin
            send_request(MODE_ALLOC, pick_size(), $urandom_range(0, 65535));
         end
      end
   endtask

   // result checking
   always @(posedge clock) begin
      grant_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_granted_address, 0);
         end else begin
            w = pending_grants.pop_front();
            n_checked++;
            if (rsp_granted_address !== w.granted_address)
               report_mismatch("granted_address", rsp_granted_address, w.granted_address);
            if (rsp_ok !== w.ok)
               report_mismatch("ok", rsp_ok, w.ok);
         end
      end
   end

   // receiver stall patterns
   int stall_mode = 0, stall_left = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 300);
      end
      stall_left--;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   initial begin
      #5ms;
      $display("buddy_block_allocator verification failed");
      $finish;
   end

   initial begin
      clear_heap();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_size_extremes();
      test_exhaustion();
      drain();
      test_random_traffic(650);
      drain();
      test_random_traffic(650);
      drain();
      $display("covered %0d allocates (%0d failed) and %0d frees, %0d results checked",
               n_alloc, n_fail, n_free, n_checked);
      if (errors == 0) begin
         $display("buddy_block_allocator verification clean");
      end else begin
         $display("buddy_block_allocator verification failed");
      end
      $finish;
   end

endmodule
